>>> rtl/planar_pose_dead_reckoning_assert.svh
// Assertion macros shared by the planar pose dead reckoning RTL
`ifndef PLANAR_POSE_DEAD_RECKONING_ASSERT_SVH
`define PLANAR_POSE_DEAD_RECKONING_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PPDR_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PPDR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPDR_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define PPDR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/ppdr_pkg.sv
// Package: types, constants and the arctangent table of the pose integrator
package ppdr_pkg;

    // operand widths of the shared serial multipliers
    localparam int PPDR_MUL_W = 32;
    // CORDIC datapath and iteration count
    localparam int PPDR_TRIG_W = 32;
    localparam int PPDR_CORDIC_ITERS = 24;

    localparam logic [15:0] PPDR_TIME_STEP_RESET = 16'd2185;
    localparam logic signed [31:0] PPDR_X_RESET = 32'sd327680;
    // round(2^32 / (2*pi)): rad to 32-bit binary angle
    localparam logic [31:0] PPDR_BAM_PER_RAD = 32'd683565276;
    // 1/K CORDIC gain in Q2.30
    localparam logic signed [31:0] PPDR_CORDIC_GAIN = 32'sd652032874;
    localparam logic [16:0] PPDR_Q14_ONE = 17'd16384;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_ROT1,
        S_MUL3,
        S_SAT
    } t_state;

    // status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    // atan(2^-i) with 2^32 = 2*pi
    function automatic logic [31:0] ppdr_atan(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/ppdr_serial_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
module ppdr_serial_mul #(
    parameter int A_W = ppdr_pkg::PPDR_MUL_W,
    parameter int B_W = ppdr_pkg::PPDR_MUL_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [A_W-1:0]         i_a,
    input  logic [B_W-1:0]         i_b,
    output ppdr_pkg::t_unit_stat   o_stat,
    output logic [A_W+B_W-1:0]     o_prod
);
    import ppdr_pkg::*;

    localparam int CW = (B_W > 1) ? $clog2(B_W) : 1;

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [A_W-1:0]     r_a;
    logic [A_W+B_W-1:0] r_acc;
    logic [A_W:0]       w_sum;

    // upper half plus multiplicand when the current multiplier bit is set
    assign w_sum = {1'b0, r_acc[A_W+B_W-1:B_W]} + (r_acc[0] ? {1'b0, r_a} : '0);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(B_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // accumulator: multiplier bits shift out at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_acc <= {{A_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_acc <= {w_sum, r_acc[B_W-1:1]};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_acc;

endmodule

>>> rtl/ppdr_cordic.sv
// Iterative rotation-mode CORDIC: sine and cosine of a 32-bit binary angle
module ppdr_cordic #(
    parameter int ITERS = ppdr_pkg::PPDR_CORDIC_ITERS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic [31:0]                             i_angle,
    output ppdr_pkg::t_unit_stat                    o_stat,
    output logic signed [ppdr_pkg::PPDR_TRIG_W-1:0] o_sin,
    output logic signed [ppdr_pkg::PPDR_TRIG_W-1:0] o_cos
);
    import ppdr_pkg::*;

    localparam int IW = (ITERS > 1) ? $clog2(ITERS) : 1;

    logic                          r_busy;
    logic                          r_fin;
    logic                          r_done;
    logic [IW-1:0]                 r_it;
    logic                          r_flip;
    logic signed [PPDR_TRIG_W-1:0] r_x;
    logic signed [PPDR_TRIG_W-1:0] r_y;
    logic signed [32:0]            r_z;

    logic [31:0]                   w_fold;
    logic                          w_flip;
    logic [31:0]                   w_a;
    logic signed [PPDR_TRIG_W-1:0] w_xs;
    logic signed [PPDR_TRIG_W-1:0] w_ys;
    logic signed [32:0]            w_atan;

    // fold the left half-plane onto the right one
    assign w_fold = i_angle + 32'h4000_0000;
    assign w_flip = w_fold[31];
    assign w_a    = {i_angle[31] ^ w_flip, i_angle[30:0]};

    assign w_xs   = r_x >>> r_it;
    assign w_ys   = r_y >>> r_it;
    assign w_atan = $signed({1'b0, ppdr_atan(5'(r_it))});

    // control: ITERS micro-rotations, then a final step that undoes the fold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_fin  <= 1'b0;
            r_done <= r_fin;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_it == IW'(ITERS - 1))) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_it   <= '0;
            r_flip <= w_flip;
            r_x    <= PPDR_CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= $signed({w_a[31], w_a});
        end else if (r_busy) begin
            r_it <= r_it + 1'b1;
            if (!r_z[32]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end
        end else if (r_fin && r_flip) begin
            r_x <= -r_x;
            r_y <= -r_y;
        end
    end

    assign o_stat.busy = r_busy | r_fin;
    assign o_stat.done = r_done;
    assign o_sin       = r_y;
    assign o_cos       = r_x;

endmodule

>>> rtl/planar_pose_dead_reckoning.sv
// Top level: fixed-point unicycle dead reckoning of planar pose
// Items are processed one at a time: a new item is accepted only in the idle state.
// Each item runs three bit-serial multiplies, a CORDIC rotation, then saturation
// and result load, all in series.
// The result sits in an output register, so the next item is taken while it waits.
// Synchronous active-low reset: x = 5.0 m, y = 0, heading = 0, time step = 2185 (about 1/30 s).
`include "planar_pose_dead_reckoning_assert.svh"
module planar_pose_dead_reckoning (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_speed,
    input  logic signed [15:0] i_yaw_rate,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [15:0] o_heading,
    output logic signed [15:0] o_quat_z,
    output logic signed [15:0] o_quat_w
);
    import ppdr_pkg::*;

    localparam int PW = 2 * PPDR_MUL_W;

    t_state                 r_state;
    t_state                 n_state;
    logic [15:0]            r_time_step;
    logic signed [31:0]     r_x;
    logic signed [31:0]     r_y;
    logic [15:0]            r_head;
    logic                   r_out_valid;
    logic signed [31:0]     r_out_x;
    logic signed [31:0]     r_out_y;
    logic [15:0]            r_out_head;
    logic [15:0]            r_out_qz;
    logic [15:0]            r_out_qw;
    logic                   r_spd_neg;
    logic                   r_yr_neg;
    logic                   r_s_neg;
    logic                   r_c_neg;
    logic [31:0]            r_sd_mag;
    logic [24:0]            r_inc_x;
    logic [24:0]            r_inc_y;

    logic                   w_in_xfer;
    logic [15:0]            w_spd_mag;
    logic [15:0]            w_yr_mag;
    logic                   w_ma_start;
    logic                   w_mb_start;
    logic [PPDR_MUL_W-1:0]  w_ma_a;
    logic [PPDR_MUL_W-1:0]  w_ma_b;
    logic [PPDR_MUL_W-1:0]  w_mb_a;
    logic [PPDR_MUL_W-1:0]  w_mb_b;
    t_unit_stat             w_ma_stat;
    t_unit_stat             w_mb_stat;
    logic [PW-1:0]          w_ma_prod;
    logic [PW-1:0]          w_mb_prod;
    logic                   w_cor_start;
    logic [31:0]            w_cor_angle;
    t_unit_stat             w_cor_stat;
    logic signed [31:0]     w_sin;
    logic signed [31:0]     w_cos;
    logic [31:0]            w_s_mag;
    logic [31:0]            w_c_mag;
    logic [15:0]            w_d16;
    logic [15:0]            w_head_new;
    logic signed [32:0]     w_sum_x;
    logic signed [32:0]     w_sum_y;
    logic signed [32:0]     w_ext_x;
    logic signed [32:0]     w_ext_y;
    logic signed [31:0]     w_x_sat;
    logic signed [31:0]     w_y_sat;
    logic                   w_out_load;

    // Q2.30 to Q1.14, round half away from zero, clamp to +-1.0
    function automatic logic [15:0] q14_round(input logic signed [31:0] v);
        logic [31:0] mag;
        logic [16:0] rnd;
        logic [16:0] lim;
        mag = v[31] ? 32'(-v) : 32'(v);
        rnd = {1'b0, mag[31:16]} + {16'b0, mag[15]};
        lim = (rnd > PPDR_Q14_ONE) ? PPDR_Q14_ONE : rnd;
        return v[31] ? 16'(-lim) : lim[15:0];
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;

    // magnitudes; signs travel separately
    assign w_spd_mag = i_speed[15] ? 16'(-i_speed) : 16'(i_speed);
    assign w_yr_mag  = i_yaw_rate[15] ? 16'(-i_yaw_rate) : 16'(i_yaw_rate);
    assign w_s_mag   = w_sin[31] ? 32'(-w_sin) : 32'(w_sin);
    assign w_c_mag   = w_cos[31] ? 32'(-w_cos) : 32'(w_cos);

    // heading step: rounded |yr*dt*K| >> 44, applied modulo 2^16
    assign w_d16      = w_ma_prod[59:44] + {15'b0, w_ma_prod[43]};
    assign w_head_new = r_yr_neg ? (r_head - w_d16) : (r_head + w_d16);

    // position update with saturation
    assign w_ext_x = (r_spd_neg ^ r_s_neg) ? -$signed({8'b0, r_inc_x})
                                           : $signed({8'b0, r_inc_x});
    assign w_ext_y = (r_spd_neg ^ r_c_neg) ? $signed({8'b0, r_inc_y})
                                           : -$signed({8'b0, r_inc_y});
    assign w_sum_x = $signed({r_x[31], r_x}) + w_ext_x;
    assign w_sum_y = $signed({r_y[31], r_y}) + w_ext_y;
    assign w_x_sat = (w_sum_x[32] != w_sum_x[31])
                   ? (w_sum_x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : w_sum_x[31:0];
    assign w_y_sat = (w_sum_y[32] != w_sum_y[31])
                   ? (w_sum_y[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : w_sum_y[31:0];

    // sequencer: next state and unit starts
    always_comb begin
        n_state     = r_state;
        w_ma_start  = 1'b0;
        w_mb_start  = 1'b0;
        w_cor_start = 1'b0;
        w_out_load  = 1'b0;
        w_ma_a      = {16'b0, w_yr_mag};
        w_ma_b      = {16'b0, r_time_step};
        w_mb_a      = {16'b0, w_spd_mag};
        w_mb_b      = {16'b0, r_time_step};
        w_cor_angle = {w_head_new, 16'b0};
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    w_ma_start = 1'b1;
                    w_mb_start = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin
                if (w_ma_stat.done) begin
                    w_ma_start = 1'b1;
                    w_ma_a     = w_ma_prod[PPDR_MUL_W-1:0];
                    w_ma_b     = PPDR_BAM_PER_RAD;
                    n_state    = S_MUL2;
                end
            end
            S_MUL2: begin
                if (w_ma_stat.done) begin
                    w_cor_start = 1'b1;
                    n_state     = S_ROT1;
                end
            end
            S_ROT1: begin
                if (w_cor_stat.done) begin
                    w_ma_start  = 1'b1;
                    w_mb_start  = 1'b1;
                    w_ma_a      = r_sd_mag;
                    w_ma_b      = w_s_mag;
                    w_mb_a      = r_sd_mag;
                    w_mb_b      = w_c_mag;
                    // half heading for the quaternion terms runs beside the multiplies
                    w_cor_start = 1'b1;
                    w_cor_angle = {r_head[15], r_head, 15'b0};
                    n_state     = S_MUL3;
                end
            end
            S_MUL3: begin
                if (w_ma_stat.done) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register, pose state, configuration, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time_step <= PPDR_TIME_STEP_RESET;
            r_x         <= PPDR_X_RESET;
            r_y         <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_time_step <= i_cfg_data;
            end
            if ((r_state == S_MUL2) && w_ma_stat.done) begin
                r_head <= w_head_new;
            end
            if (w_out_load) begin
                r_x         <= w_x_sat;
                r_y         <= w_y_sat;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-item working registers and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_spd_neg <= i_speed[15];
            r_yr_neg  <= i_yaw_rate[15];
        end
        if ((r_state == S_MUL1) && w_mb_stat.done) begin
            r_sd_mag <= w_mb_prod[31:0];
        end
        if ((r_state == S_ROT1) && w_cor_stat.done) begin
            r_s_neg <= w_sin[31];
            r_c_neg <= w_cos[31];
        end
        // rounded |sd*trig| >> 38
        if ((r_state == S_MUL3) && w_ma_stat.done) begin
            r_inc_x <= {1'b0, w_ma_prod[61:38]} + {24'b0, w_ma_prod[37]};
            r_inc_y <= {1'b0, w_mb_prod[61:38]} + {24'b0, w_mb_prod[37]};
        end
        if (w_out_load) begin
            r_out_x    <= w_x_sat;
            r_out_y    <= w_y_sat;
            r_out_head <= r_head;
            r_out_qz   <= q14_round(w_sin);
            r_out_qw   <= q14_round(w_cos);
        end
    end

    ppdr_serial_mul #(
        .A_W (PPDR_MUL_W),
        .B_W (PPDR_MUL_W)
    ) u_mul_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ma_start),
        .i_a     (w_ma_a),
        .i_b     (w_ma_b),
        .o_stat  (w_ma_stat),
        .o_prod  (w_ma_prod)
    );

    ppdr_serial_mul #(
        .A_W (PPDR_MUL_W),
        .B_W (PPDR_MUL_W)
    ) u_mul_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mb_start),
        .i_a     (w_mb_a),
        .i_b     (w_mb_b),
        .o_stat  (w_mb_stat),
        .o_prod  (w_mb_prod)
    );

    ppdr_cordic #(
        .ITERS (PPDR_CORDIC_ITERS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_angle (w_cor_angle),
        .o_stat  (w_cor_stat),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;
    assign o_heading   = r_out_head;
    assign o_quat_z    = r_out_qz;
    assign o_quat_w    = r_out_qw;

    // both position multiplies run in lockstep
    `PPDR_ASSERT_IMP(a_mul_lockstep, i_clk, i_rst_n, (r_state == S_MUL3) && w_ma_stat.done, w_mb_stat.done, "position multipliers out of step")
    // half-angle rotation is finished before the result is built
    `PPDR_ASSERT_IMP(a_cordic_done_at_sat, i_clk, i_rst_n, r_state == S_SAT, !w_cor_stat.busy, "quaternion rotation still running at result load")
    // a pending result blocks the next one
    `PPDR_ASSERT_NEXT(a_out_slot_hold, i_clk, i_rst_n, (r_state == S_SAT) && r_out_valid && !i_out_ready, r_state == S_SAT, "result overwritten before transfer")
    // heading moves only when the heading multiply completes
    `PPDR_ASSERT_NEXT(a_head_stable, i_clk, i_rst_n, !((r_state == S_MUL2) && w_ma_stat.done), $stable(r_head), "heading changed outside its update")

endmodule

>>> tb/sv/tb_top.sv
// Testbench for the planar pose dead reckoning block: directed table, random ticks, self-check
`timescale 1ns / 1ps

module tb_top;

    // cycles with no transfer on any channel before the run is declared hung
    localparam int STALL_LIMIT = 4000;
    // cycles of silence allowed at the end
    localparam int TAIL_CYCLES = 150;
    localparam int N_DIR = 24;
    localparam int N_PHASES = 8;
    localparam int TICKS_PER_PHASE = 156;

    // fixed-point constants of the integrator
    localparam longint RAD_TO_BAM = 64'sd683565276;
    localparam longint CORDIC_K_Q30 = 64'sd652032874;
    localparam longint Q14_ONE = 64'sd16384;
    localparam logic [15:0] DT_RESET = 16'd2185;
    localparam logic signed [31:0] X_HOME = 32'sd327680;
    // largest heading step used when steering onto minus pi
    localparam int AIM_MAX_STEP = 20000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] hdg;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } t_pose;

    typedef enum logic [1:0] {
        ROW_TICK,   // tick checked against the predictor
        ROW_KNOWN,  // tick with the pose typed in
        ROW_AIM,    // tick whose yaw rate steers the heading onto minus pi
        ROW_CFG     // time step write
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [15:0]        dt;
        logic signed [15:0] spd;
        logic signed [15:0] yr;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] hdg;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [15:0] i_speed;
    logic signed [15:0] i_yaw_rate;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_pos_x;
    logic signed [31:0] o_pos_y;
    logic signed [15:0] o_heading;
    logic signed [15:0] o_quat_z;
    logic signed [15:0] o_quat_w;

    planar_pose_dead_reckoning u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_speed     (i_speed),
        .i_yaw_rate  (i_yaw_rate),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_heading   (o_heading),
        .o_quat_z    (o_quat_z),
        .o_quat_w    (o_quat_w)
    );

    // predictor state, mirrors the block
    logic signed [31:0] est_x = X_HOME;
    logic signed [31:0] est_y = '0;
    logic [15:0]        est_hdg = '0;
    logic [15:0]        est_dt = DT_RESET;

    t_pose    pending_poses[$];
    t_dir_row dir_tab [N_DIR];
    int       err_count = 0;
    int       quiet_cycles = 0;
    int       stall_left = 0;
    bit       idle_on = 1'b1;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // round to nearest, halves away from zero
    function automatic longint round_shift(input longint v, input int unsigned sh);
        longint half;
        half = 64'sd1 <<< (sh - 1);
        if (v >= 0)
            return (v + half) >>> sh;
        return -((-v + half) >>> sh);
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // atan(2^-i), 2^32 = 2*pi
    function automatic longint arc_step(input int i);
        case (i)
            0:  return 536870912;
            1:  return 316933406;
            2:  return 167458907;
            3:  return 85004756;
            4:  return 42667331;
            5:  return 21354465;
            6:  return 10679838;
            7:  return 5340245;
            8:  return 2670163;
            9:  return 1335087;
            10: return 667544;
            11: return 333772;
            12: return 166886;
            13: return 83443;
            14: return 41722;
            15: return 20861;
            16: return 10430;
            17: return 5215;
            18: return 2608;
            19: return 1304;
            20: return 652;
            21: return 326;
            22: return 163;
            23: return 81;
            default: return 0;
        endcase
    endfunction

    // 24-step rotation, angle 2^32 = 2*pi, results in Q2.30
    function automatic void cordic_sincos(input logic [31:0] ang,
                                          output longint sn, output longint cs);
        logic [31:0] t;
        logic [31:0] a;
        logic        flip;
        longint      x, y, z, xs, ys;
        t = ang + 32'h4000_0000;
        flip = t[31];
        // fold the left half plane onto the right one
        a = flip ? ang + 32'h8000_0000 : ang;
        z = longint'($signed(a));
        x = CORDIC_K_Q30;
        y = 0;
        for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - arc_step(i);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + arc_step(i);
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    function automatic logic signed [15:0] to_q14(input longint v30);
        longint v;
        v = round_shift(v30, 16);
        if (v > Q14_ONE)
            v = Q14_ONE;
        if (v < -Q14_ONE)
            v = -Q14_ONE;
        return v[15:0];
    endfunction

    function automatic longint heading_delta(input logic signed [15:0] yr,
                                             input logic [15:0] dt);
        return round_shift(longint'(yr) * longint'(dt) * RAD_TO_BAM, 44);
    endfunction

    // one tick of the integrator: heading first, then position on the new heading
    function automatic t_pose advance_pose(input logic signed [15:0] spd,
                                           input logic signed [15:0] yr);
        t_pose       r;
        longint      d, s30, c30, sd;
        logic [31:0] half;
        d = heading_delta(yr, est_dt);
        est_hdg = est_hdg + d[15:0];
        cordic_sincos({est_hdg, 16'h0000}, s30, c30);
        sd = longint'(spd) * longint'(est_dt);
        est_x = clip32(longint'(est_x) + round_shift(sd * s30, 38));
        est_y = clip32(longint'(est_y) - round_shift(sd * c30, 38));
        // half angle, sign extended to the 32-bit binary angle
        half = {est_hdg[15], est_hdg, 15'd0};
        cordic_sincos(half, s30, c30);
        r.x = est_x;
        r.y = est_y;
        r.hdg = est_hdg;
        r.qz = to_q14(s30);
        r.qw = to_q14(c30);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // one input transfer; the expected pose is queued at acceptance
    task automatic send_tick(input logic signed [15:0] spd, input logic signed [15:0] yr,
                             input bit typed, input logic signed [31:0] tx,
                             input logic signed [31:0] ty, input logic signed [15:0] th);
        int    gap;
        t_pose p;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_speed = spd;
        i_yaw_rate = yr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        p = advance_pose(spd, yr);
        if (typed) begin
            p.x = tx;
            p.y = ty;
            p.hdg = th;
        end
        pending_poses.push_back(p);
    endtask

    // stop sending and wait for every outstanding pose
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_poses.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_time_step(input logic [15:0] dt);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = dt;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        est_dt = dt;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // output stalls in random bursts, only while idle_on is set
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready = 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_out_ready = 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            i_out_ready = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic compare_field(input string fld, input logic signed [31:0] e,
                                 input logic signed [31:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fld, e, a);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_pose want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_poses.size() == 0) begin
                $display("%0t: result with none expected: x %0d y %0d heading %0d",
                         $time, o_pos_x, o_pos_y, o_heading);
                err_count++;
            end else begin
                want = pending_poses.pop_front();
                compare_field("pos_x", want.x, o_pos_x);
                compare_field("pos_y", want.y, o_pos_y);
                compare_field("heading", want.hdg, o_heading);
                compare_field("quat_z", want.qz, o_quat_z);
                compare_field("quat_w", want.qw, o_quat_w);
            end
        end
    end

    // watchdog: no transfer on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    initial begin
        t_dir_row           row;
        logic signed [15:0] want_step;
        logic signed [15:0] aim_yr;
        logic signed [15:0] run_spd;
        logic signed [15:0] run_yr;
        longint             err, best_err;
        int                 sent, run_len, pick;
        bit                 paused;
        logic [15:0]        dt;

        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_speed = '0;
        i_yaw_rate = '0;
        i_out_ready = 1'b0;

        // directed ticks; the pose is typed in after reset and under a zero time step
        dir_tab = '{
            '{ROW_KNOWN, 16'd0,     16'sd0,      16'sd0,      X_HOME, 32'sd0, 16'sd0},
            '{ROW_CFG,   16'd0,     16'sd0,      16'sd0,      32'sd0, 32'sd0, 16'sd0},
            '{ROW_KNOWN, 16'd0,     16'sh7FFF,   16'sh7FFF,   X_HOME, 32'sd0, 16'sd0},
            '{ROW_KNOWN, 16'd0,     16'sh8000,   16'sh8000,   X_HOME, 32'sd0, 16'sd0},
            '{ROW_KNOWN, 16'd0,     16'sh8000,   16'sh7FFF,   X_HOME, 32'sd0, 16'sd0},
            '{ROW_CFG,   16'd65535, 16'sd0,      16'sd0,      32'sd0, 32'sd0, 16'sd0},
            '{ROW_TICK,  16'd0,     16'sh7FFF,   16'sd0,      32'sd0, 32'sd0, 16'sd0},
            '{ROW_TICK,  16'd0,     16'sh8000,   16'sd0,      32'sd0, 32'sd0, 16'sd0},
            '{ROW_TICK,  16'd0,     16'sd0,      16'sh7FFF,   32'sd0, 32'sd0, 16'sd0},
            '{ROW_TICK,  16'd0,     16'sd0,      16'sh8000,   32'sd0, 32'sd0, 16'sd0},
            '{ROW_TICK,  16'd0,     16'sh7FFF,   16'sh7FFF,   32'sd0, 32'sd0, 16'sd0},
            '{ROW_TICK,  16'd0,     16'sh8000,   16'sh8000,   32'sd0, 32'sd0, 16'sd0},
            '{ROW_TICK,  16'd0,     16'sd1,      -16'sd1,     32'sd0, 32'sd0, 16'sd0},
            '{ROW_TICK,  16'd0,     -16'sd1,     16'sd1,      32'sd0, 32'sd0, 16'sd0},
            '{ROW_CFG,   16'd1,     16'sd0,      16'sd0,      32'sd0, 32'sd0, 16'sd0},
            '{ROW_TICK,  16'd0,     16'sh7FFF,   16'sh7FFF,   32'sd0, 32'sd0, 16'sd0},
            '{ROW_TICK,  16'd0,     16'sh8000,   16'sh8000,   32'sd0, 32'sd0, 16'sd0},
            '{ROW_CFG,   16'd16384, 16'sd0,      16'sd0,      32'sd0, 32'sd0, 16'sd0},
            '{ROW_AIM,   16'd0,     16'sd256,    16'sd0,      32'sd0, 32'sd0, 16'sd0},
            '{ROW_AIM,   16'd0,     16'sd256,    16'sd0,      32'sd0, 32'sd0, 16'sd0},
            '{ROW_TICK,  16'd0,     16'sd0,      16'sd0,      32'sd0, 32'sd0, 16'sd0},
            '{ROW_CFG,   16'd2185,  16'sd0,      16'sd0,      32'sd0, 32'sd0, 16'sd0},
            '{ROW_TICK,  16'd0,     16'sh5555,   16'sh2AAA,   32'sd0, 32'sd0, 16'sd0},
            '{ROW_TICK,  16'd0,     16'shAAAA,   16'shD555,   32'sd0, 32'sd0, 16'sd0}
        };

        // hold synchronous reset, then release it
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part
        for (int k = 0; k < N_DIR; k++) begin
            row = dir_tab[k];
            case (row.kind)
                ROW_CFG: begin
                    write_time_step(row.dt);
                end
                ROW_AIM: begin
                    // pick the yaw rate whose step best matches the clamped step toward minus pi
                    want_step = 16'h8000 - est_hdg;
                    if (want_step > AIM_MAX_STEP)
                        want_step = AIM_MAX_STEP;
                    if (want_step < -AIM_MAX_STEP)
                        want_step = -AIM_MAX_STEP;
                    best_err = 64'sd1 <<< 40;
                    aim_yr = '0;
                    for (int c = -32768; c <= 32767; c++) begin
                        err = heading_delta(16'(c), est_dt) - longint'(want_step);
                        if (err < 0)
                            err = -err;
                        if (err < best_err) begin
                            best_err = err;
                            aim_yr = 16'(c);
                        end
                    end
                    send_tick(row.spd, aim_yr, 1'b0, '0, '0, '0);
                end
                ROW_KNOWN: begin
                    send_tick(row.spd, row.yr, 1'b1, row.x, row.y, row.hdg);
                end
                default: begin
                    send_tick(row.spd, row.yr, 1'b0, '0, '0, '0);
                end
            endcase
        end

        // random part: one time step per phase, no idling in phase 3 and the last two phases
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: dt = DT_RESET;
                1: dt = 16'd65535;
                2: dt = 16'd1;
                3: dt = 16'd65535;
                4: dt = 16'd0;
                5: dt = 16'($urandom_range(1, 65535));
                6: dt = 16'd40000;
                default: dt = DT_RESET;
            endcase
            write_time_step(dt);
            idle_on = (p == 3 || p >= N_PHASES - 2) ? 1'b0 : 1'b1;
            sent = 0;
            paused = 1'b0;
            while (sent < TICKS_PER_PHASE) begin
                // sender holds off until the pipe is empty, once per phase
                if (!paused && sent >= TICKS_PER_PHASE / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    // noise: any speed, any yaw rate
                    send_tick(16'($urandom), 16'($urandom), 1'b0, '0, '0, '0);
                    sent++;
                end else if (pick < 85) begin
                    // cruise near full speed on a nearly straight line, drives saturation
                    run_len = $urandom_range(20, 200);
                    if ($urandom_range(0, 1))
                        run_spd = 16'sh7FFF - 16'($urandom_range(0, 800));
                    else
                        run_spd = 16'sh8000 + 16'($urandom_range(0, 800));
                    for (int n = 0; n < run_len && sent < TICKS_PER_PHASE; n++) begin
                        run_yr = 16'($urandom_range(0, 128)) - 16'sd64;
                        send_tick(run_spd, run_yr, 1'b0, '0, '0, '0);
                        sent++;
                    end
                end else begin
                    // steady turn at random speed and rate
                    run_len = $urandom_range(5, 40);
                    run_spd = 16'($urandom);
                    run_yr = 16'($urandom);
                    for (int n = 0; n < run_len && sent < TICKS_PER_PHASE; n++) begin
                        send_tick(run_spd, run_yr, 1'b0, '0, '0, '0);
                        sent++;
                    end
                end
            end
        end

        // wind down
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
